// ===== design/assert_macros.svh =====
// assertion macros for the rtl file arming_state_controller.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/asc_pkg.sv =====
// types, codes and constants of the arming state controller
`timescale 1ns / 1ps

package asc_pkg;

  localparam int NOW_W    = 32;
  localparam int RAW_W    = 11;
  localparam int US_W     = 12;
  localparam int MS_W     = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] led_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_BOOT   = 2'd0;
  localparam mode_t MODE_PREARM = 2'd1;
  localparam mode_t MODE_ARMED  = 2'd2;
  localparam mode_t MODE_ERROR  = 2'd3;

  localparam led_t LED_BLUE  = 2'd0;
  localparam led_t LED_RED   = 2'd1;
  localparam led_t LED_GREEN = 2'd2;
  localparam led_t LED_OFF   = 2'd3;

  localparam cfg_idx_t REG_NO_SIGNAL     = 3'd0;
  localparam cfg_idx_t REG_ARM_THRESHOLD = 3'd1;
  localparam cfg_idx_t REG_DETECT_TMO    = 3'd2;
  localparam cfg_idx_t REG_HB_INTERVAL   = 3'd3;
  localparam cfg_idx_t REG_PRE_ARM_DELAY = 3'd4;

  localparam logic [US_W-1:0] NO_SIGNAL_RST     = 12'd900;
  localparam logic [US_W-1:0] ARM_THRESHOLD_RST = 12'd1500;
  localparam logic [MS_W-1:0] DETECT_TMO_RST    = 16'd5000;
  localparam logic [MS_W-1:0] HB_INTERVAL_RST   = 16'd1000;
  localparam logic [MS_W-1:0] PRE_ARM_DELAY_RST = 16'd10000;

  localparam logic [RAW_W-1:0] RAW_LOW = 11'd172;
  localparam logic [US_W-1:0]  US_LOW  = 12'd988;

  // (d * 1024) / 1639 == (d * RECIP) >> RECIP_SHIFT for every 11-bit d
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP = 22'd2620481;
  localparam int PROD_W = RAW_W + RECIP_W;

endpackage

// ===== design/arming_state_controller.sv =====
// arming state controller: mode machine, heartbeat timing and arm channel scaling
// an input transaction is registered in the input register, then in the result register
// throughput: one transaction per cycle while unstalled; mode and times feed back to the next one
// the result register stalls the input register only while out_stall holds a full result
// reset (synchronous, rst_n low): boot detect mode, times zero, registers to defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arming_state_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  asc_pkg::cfg_idx_t           cfg_index,
  input  logic [asc_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [asc_pkg::NOW_W-1:0]   in_now_ms,
  input  logic [asc_pkg::RAW_W-1:0]   in_arm_raw,
  input  logic                        in_link_active,
  input  logic                        in_vtx_detected,
  output logic                        out_valid,
  input  logic                        out_stall,
  output asc_pkg::mode_t              out_mode,
  output asc_pkg::led_t               out_led_colour,
  output logic [asc_pkg::US_W-1:0]    out_arm_us,
  output logic                        out_first_beat_start,
  output logic                        out_heartbeat_send,
  output logic                        out_heartbeat_armed,
  output logic                        out_error_flash_tick
);
  import asc_pkg::*;

  // configuration registers
  logic [US_W-1:0] no_signal_r, arm_thr_r;
  logic [MS_W-1:0] det_tmo_r, hb_int_r, pre_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_signal_r <= NO_SIGNAL_RST;
      arm_thr_r   <= ARM_THRESHOLD_RST;
      det_tmo_r   <= DETECT_TMO_RST;
      hb_int_r    <= HB_INTERVAL_RST;
      pre_delay_r <= PRE_ARM_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NO_SIGNAL:     no_signal_r <= cfg_wdata[US_W-1:0];
        REG_ARM_THRESHOLD: arm_thr_r   <= cfg_wdata[US_W-1:0];
        REG_DETECT_TMO:    det_tmo_r   <= cfg_wdata;
        REG_HB_INTERVAL:   hb_int_r    <= cfg_wdata;
        REG_PRE_ARM_DELAY: pre_delay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic             s1_vld_r;
  logic [NOW_W-1:0] s1_now_r;
  logic [RAW_W-1:0] s1_raw_r;
  logic             s1_link_r, s1_det_r;

  logic out_vld_r;
  logic adv;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_now_r  <= in_now_ms;
      s1_raw_r  <= in_arm_raw;
      s1_link_r <= in_link_active;
      s1_det_r  <= in_vtx_detected;
    end
  end

  // arm channel scaling: clamp low end, constant reciprocal multiply, zero when the link is down
  logic [RAW_W-1:0]  raw_c, raw_d;
  logic [PROD_W-1:0] prod;
  logic [US_W-1:0]   us_c;
  logic              present;

  always_comb begin
    raw_c = (s1_raw_r < RAW_LOW) ? RAW_LOW : s1_raw_r;
    raw_d = raw_c - RAW_LOW;
    prod  = {{RECIP_W{1'b0}}, raw_d} * {{RAW_W{1'b0}}, RECIP};
    us_c  = s1_link_r ? (US_LOW + {1'b0, prod[RECIP_SHIFT +: RAW_W]}) : '0;
    present = s1_link_r && (us_c > no_signal_r);
  end

  // mode machine state
  mode_t            mode_r, mode_nxt;
  logic [NOW_W-1:0] entry_r, entry_nxt;
  logic [NOW_W-1:0] beat_r, beat_nxt;
  logic [NOW_W-1:0] since_entry, since_beat;
  logic             hb_due;
  logic             fbs, hb, hb_armed, flash;
  led_t             led;

  always_comb begin
    since_entry = s1_now_r - entry_r;
    since_beat  = s1_now_r - beat_r;
    hb_due      = since_beat > {{(NOW_W-MS_W){1'b0}}, hb_int_r};
    mode_nxt  = mode_r;
    entry_nxt = entry_r;
    beat_nxt  = beat_r;
    fbs       = 1'b0;
    hb        = 1'b0;
    hb_armed  = 1'b0;
    flash     = 1'b0;
    case (mode_r)
      MODE_BOOT: begin
        if (s1_det_r) begin
          fbs       = 1'b1;
          mode_nxt  = MODE_PREARM;
          entry_nxt = s1_now_r;
        end else if (since_entry > {{(NOW_W-MS_W){1'b0}}, det_tmo_r}) begin
          mode_nxt  = MODE_ERROR;
          entry_nxt = s1_now_r;
        end
      end
      MODE_PREARM: begin
        if (hb_due) begin
          hb       = 1'b1;
          beat_nxt = s1_now_r;
        end
        // switch high arms at once; without signal arm after the delay
        if (present) begin
          if (us_c >= arm_thr_r) begin
            mode_nxt  = MODE_ARMED;
            entry_nxt = s1_now_r;
          end
        end else if (since_entry > {{(NOW_W-MS_W){1'b0}}, pre_delay_r}) begin
          mode_nxt  = MODE_ARMED;
          entry_nxt = s1_now_r;
        end
      end
      MODE_ARMED: begin
        if (hb_due) begin
          hb       = 1'b1;
          hb_armed = 1'b1;
          beat_nxt = s1_now_r;
        end
        if (present && us_c < arm_thr_r) begin
          mode_nxt  = MODE_PREARM;
          entry_nxt = s1_now_r;
        end
      end
      default: begin
        flash = 1'b1;
      end
    endcase
    case (mode_nxt)
      MODE_BOOT:   led = LED_BLUE;
      MODE_PREARM: led = LED_RED;
      MODE_ARMED:  led = LED_GREEN;
      default:     led = LED_OFF;
    endcase
  end

  logic fire;
  assign fire = s1_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BOOT;
      entry_r <= '0;
      beat_r  <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      entry_r <= entry_nxt;
      beat_r  <= beat_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mode             <= mode_nxt;
      out_led_colour       <= led;
      out_arm_us           <= us_c;
      out_first_beat_start <= fbs;
      out_heartbeat_send   <= hb;
      out_heartbeat_armed  <= hb_armed;
      out_error_flash_tick <= flash;
    end
  end

  assign out_valid = out_vld_r;

  `ASC_ASSERT_NEXT(a_error_sticky, mode_r == MODE_ERROR, mode_r == MODE_ERROR, "error mode left")
  `ASC_ASSERT_SAME(a_fbs_prearm, out_vld_r && out_first_beat_start, out_mode == MODE_PREARM, "first beat outside pre-arm")
  `ASC_ASSERT_SAME(a_hb_armed, out_vld_r && out_heartbeat_armed, out_heartbeat_send && out_mode != MODE_BOOT, "armed flag without heartbeat")
  `ASC_ASSERT_SAME(a_flash_error, out_vld_r && out_error_flash_tick, out_mode == MODE_ERROR && !out_heartbeat_send, "flash tick outside error")

endmodule
